// ===== hw/rtl/b64e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants for the line-wrapped Base64 encoder
// Alphabet lookup, special characters, job record passed front to back.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  // characters per output line before a CR LF
  localparam logic [6:0] LINE_CHARS = 7'd76;
  localparam logic [6:0] GROUP_CHARS = 7'd4;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // output sequence positions inside one job
  localparam logic [2:0] POS_FIRST    = 3'd0;
  localparam logic [2:0] POS_LAST_SYM = 3'd3;
  localparam logic [2:0] POS_CR       = 3'd4;
  localparam logic [2:0] POS_LF       = 3'd5;

  // one item's worth of output: up to four group characters, then an optional CR LF
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            has_group;
    logic            crlf;
  } job_t;

  // standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/base64_line_wrapped_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder: streaming MIME Base64 encoder, 76-column lines
// One message byte per input beat; alphabet, '=', CR and LF out, one a beat.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | data_byte[7:0], has_byte, end_of_message
//  out     | out_valid / out_ready| out_char[7:0], last_of_run
//
//  Flow: the front takes one input beat per cycle while the job queue
//  (QUEUE_DEPTH entries) has room. The back sequencer emits one character
//  per cycle while the output register is free or out_ready is high; an
//  item produces up to 6 characters. Sustained rate is set by the output
//  port, 4/3 characters per byte plus 2 per 76-char line.
//  Reset (rst, synchronous) clears pending bytes, line column, queue and the
//  output valid flag. Output stalls back up through the queue into in_ready.
//
module base64_line_wrapped_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run
);
  import b64e_pkg::*;

  // front -> queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue -> back
  logic pop;
  job_t q_job;
  logic q_not_empty;

  // front: pending bytes, column tracking, job build
  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  // decoupling queue so a stalled output does not stall the front at once
  b64e_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_job   (q_job),
    .not_empty (q_not_empty)
  );

  // back: character sequencer and output register
  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (q_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

`ifndef SYNTH
  // LF only ever closes a run
  a_lf_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_char == CHAR_LF) |-> last_of_run)
    else $error("LF beat not marked last_of_run");

  // a CR beat never closes a run; its LF follows in the same run
  a_cr_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_char == CHAR_CR) |-> !last_of_run)
    else $error("CR beat marked last_of_run");

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into full queue");
`endif

endmodule

// ===== hw/rtl/b64e_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front: input side of the encoder
// Holds pending bytes and the line column, builds one job per item with output.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              has_byte,
  input  logic              end_of_message,
  input  logic              q_full,
  output logic              push,
  output b64e_pkg::job_t    push_job
);
  import b64e_pkg::*;

  logic [15:0] held, held_next, held_after;
  logic [1:0]  fill, fill_after, fill_next;
  logic [6:0]  column, column_next, column_sum;
  logic        take, full_group, wrap, pad2, pad3;
  logic [7:0]  ga, gb, gc;
  logic [5:0]  s0, s1, s2, s3;

  assign in_ready = !q_full;

  always_comb begin
    take       = in_valid && in_ready;
    full_group = has_byte && (fill == 2'd2);
    held_after = (has_byte && !full_group) ? {held[7:0], data_byte} : held;
    fill_after = (has_byte && !full_group) ? fill + 2'd1 : fill;
    column_sum = column + GROUP_CHARS;
    wrap       = full_group && (column_sum == LINE_CHARS);

    // group bytes: full group, or padded tail of two or one bytes
    if (full_group) begin
      ga = held[15:8];
      gb = held[7:0];
      gc = data_byte;
    end else if (fill_after == 2'd2) begin
      ga = held_after[15:8];
      gb = held_after[7:0];
      gc = 8'h00;
    end else begin
      ga = held_after[7:0];
      gb = 8'h00;
      gc = 8'h00;
    end
    pad3 = !full_group;
    pad2 = !full_group && (fill_after == 2'd1);

    s0 = ga[7:2];
    s1 = {ga[1:0], gb[7:4]};
    s2 = {gb[3:0], gc[7:6]};
    s3 = gc[5:0];

    push_job.chars[0]  = sym_char(s0);
    push_job.chars[1]  = sym_char(s1);
    push_job.chars[2]  = pad2 ? CHAR_PAD : sym_char(s2);
    push_job.chars[3]  = pad3 ? CHAR_PAD : sym_char(s3);
    push_job.has_group = full_group || (end_of_message && (fill_after != 2'd0));
    push_job.crlf      = full_group ? (wrap || end_of_message) : 1'b1;

    push = take && (full_group || end_of_message);
  end

  always_comb begin
    held_next   = held;
    fill_next   = fill;
    column_next = column;
    if (take) begin
      if (end_of_message) begin
        held_next   = '0;
        fill_next   = '0;
        column_next = '0;
      end else if (full_group) begin
        held_next   = '0;
        fill_next   = '0;
        column_next = wrap ? 7'd0 : column_sum;
      end else begin
        held_next = held_after;
        fill_next = fill_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= '0;
      fill   <= '0;
      column <= '0;
    end else begin
      held   <= held_next;
      fill   <= fill_next;
      column <= column_next;
    end
  end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue: short job FIFO between front and back
// Register-based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output b64e_pkg::job_t pop_job,
  output logic           not_empty
);
  import b64e_pkg::*;

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

// ===== hw/rtl/b64e_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back: output sequencer
// Walks one job into the output register, a character per unstalled cycle.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  b64e_pkg::job_t q_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_char,
  output logic           last_of_run
);
  import b64e_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [2:0] pos;
  logic       out_load, is_last;
  logic [7:0] sel_char;

  always_comb begin
    out_load = cur_valid && (!out_valid || out_ready);
    is_last  = cur.crlf ? (pos == POS_LF) : (pos == POS_LAST_SYM);
    pop      = q_not_empty && (!cur_valid || (out_load && is_last));
    case (pos)
      3'd0:    sel_char = cur.chars[0];
      3'd1:    sel_char = cur.chars[1];
      3'd2:    sel_char = cur.chars[2];
      3'd3:    sel_char = cur.chars[3];
      POS_CR:  sel_char = CHAR_CR;
      POS_LF:  sel_char = CHAR_LF;
      default: sel_char = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      pos       <= POS_FIRST;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        pos       <= q_job.has_group ? POS_FIRST : POS_CR;
      end else begin
        if (out_load && is_last) cur_valid <= 1'b0;
        if (out_load) pos <= pos + 3'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_job;
    if (out_load) begin
      out_char    <= sel_char;
      last_of_run <= is_last;
    end
  end

endmodule

// ===== verif/tb_base64_line_wrapped_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_line_wrapped_encoder: self-checking bench for the MIME encoder
// Drives byte beats, predicts every output character, checks it in order.
// ----------------------------------------------------------------------------
//
// A small tracker class runs its own copy of the encoder state (pending
// bytes, group fill, line column). A single monitor samples both channels
// at each rising edge, so the prediction of an input beat always lands
// before any character it causes can be compared. Both sides idle at random,
// with quiet stretches where they run back to back.
//
module tb_base64_line_wrapped_encoder;
  import b64e_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_GAP      = 14;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 20;

  // one output character with its end-of-run flag
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } b64_char_t;

  // --------------------------------------------------------------------------
  // Expected-character tracker: encoder state plus the queue of due output
  // --------------------------------------------------------------------------
  class mime_line_tracker;
    logic [15:0] held;
    logic [1:0]  fill;
    logic [6:0]  column;
    b64_char_t   due_chars[$];
    string       alphabet;
    int          errors;
    int          checked;
    int          wraps;

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      held    = '0;
      fill    = '0;
      column  = '0;
      errors  = 0;
      checked = 0;
      wraps   = 0;
    endfunction

    function void put(logic [7:0] ch);
      b64_char_t c;
      c.ch   = ch;
      c.last = 1'b0;
      due_chars.push_back(c);
    endfunction

    function void put_sym(logic [5:0] v);
      put(8'(alphabet.getc(int'(v))));
    endfunction

    // work out the characters that one accepted input beat produces
    function void take_beat(logic [7:0] b, logic hb, logic eom);
      int          start;
      logic        wrapped;
      logic [7:0]  a;
      logic [7:0]  c;
      b64_char_t   tail;
      start   = due_chars.size();
      wrapped = 1'b0;
      a       = held[15:8];
      c       = held[7:0];
      if (hb) begin
        if (fill == 2'd2) begin
          put_sym(a[7:2]);
          put_sym({a[1:0], c[7:4]});
          put_sym({c[3:0], b[7:6]});
          put_sym(b[5:0]);
          column = column + 7'd4;
          if (column >= LINE_CHARS) begin
            put(CHAR_CR);
            put(CHAR_LF);
            column  = '0;
            wrapped = 1'b1;
            wraps++;
          end
          held = '0;
          fill = '0;
        end else begin
          held = {held[7:0], b};
          fill = fill + 2'd1;
        end
      end
      if (eom) begin
        a = held[15:8];
        c = held[7:0];
        if (fill == 2'd1) begin
          put_sym(c[7:2]);
          put_sym({c[1:0], 4'b0000});
          put(CHAR_PAD);
          put(CHAR_PAD);
        end else if (fill == 2'd2) begin
          put_sym(a[7:2]);
          put_sym({a[1:0], c[7:4]});
          put_sym({c[3:0], 2'b00});
          put(CHAR_PAD);
        end
        if (!wrapped) begin
          put(CHAR_CR);
          put(CHAR_LF);
        end
        held   = '0;
        fill   = '0;
        column = '0;
      end
      if (due_chars.size() > start) begin
        tail      = due_chars.pop_back();
        tail.last = 1'b1;
        due_chars.push_back(tail);
      end
    endfunction

    function void match_char(logic [7:0] ch, logic last);
      b64_char_t want;
      if (due_chars.size() == 0) begin
        $error("out_char: expected nothing, got %02h", ch);
        errors++;
        return;
      end
      want = due_chars.pop_front();
      checked++;
      if (ch !== want.ch) begin
        $error("out_char: expected %02h, got %02h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function void close_out();
      if (due_chars.size() != 0) begin
        $error("out_char: %0d characters never arrived", due_chars.size());
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       in_valid       = 1'b0;
  logic [7:0] data_byte      = 8'h00;
  logic       has_byte       = 1'b0;
  logic       end_of_message = 1'b0;
  logic       out_ready      = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_char;
  logic       last_of_run;

  base64_line_wrapped_encoder u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .last_of_run    (last_of_run)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  mime_line_tracker tracker;
  int in_beats_driven = 0;
  int out_beats_taken = 0;
  int beats_taken     = 0;  // beats carrying a byte or an end marker
  int ignored_taken   = 0;  // no byte, no end: block should do nothing
  int messages_done   = 0;
  int idle_cycles     = 0;

  // Every fourth stretch of 20 beats runs with no idling at all.
  function automatic int pick_gap(int idx);
    return ((idx / 20) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: input beat is predicted first, then the output beat is checked.
  // Both read pre-edge values, so the order within the time step is fixed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        tracker.take_beat(data_byte, has_byte, end_of_message);
        if (has_byte || end_of_message) beats_taken++;
        else ignored_taken++;
        if (end_of_message) messages_done++;
      end
      if (out_valid && out_ready) begin
        tracker.match_char(out_char, last_of_run);
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb_base64_line_wrapped_encoder: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. valid is only dropped when a gap follows, so it never gets
  // two nonblocking updates in one step; payload changes only after a beat.
  // --------------------------------------------------------------------------
  task automatic drive_beat(input logic [7:0] b, input logic hb, input logic eom);
    int gap;
    gap = pick_gap(in_beats_driven);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    has_byte       <= hb;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    in_beats_driven++;
  endtask

  // Random-content message. With allow_bare set, idle beats are sprinkled in and
  // it may close with a bare end marker instead of on its last byte.
  task automatic drive_message(input int len, input bit allow_bare);
    bit bare_end;
    bare_end = (len == 0) || (allow_bare && ($urandom_range(0, 3) == 0));
    for (int i = 0; i < len; i++) begin
      if (allow_bare && ($urandom_range(0, 7) == 0)) begin
        drive_beat(8'($urandom), 1'b0, 1'b0);
      end
      drive_beat(8'($urandom), 1'b1, !bare_end && (i == len - 1));
    end
    if (bare_end) drive_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall before each character, quiet stretches too
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap(out_beats_taken);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      out_beats_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty message: CR LF only
    drive_beat(8'h00, 1'b0, 1'b1);
    // no byte, no end: nothing out, nothing changes
    drive_beat(8'hA5, 1'b0, 1'b0);
    // lone byte at both extremes, two pads each
    drive_beat(8'h00, 1'b1, 1'b1);
    drive_beat(8'hFF, 1'b1, 1'b1);
    // two bytes, one pad
    drive_beat(8'hFF, 1'b1, 1'b0);
    drive_beat(8'h00, 1'b1, 1'b1);
    // full groups of zero bytes and of all-ones bytes
    drive_beat(8'h00, 1'b1, 1'b0);
    drive_beat(8'h00, 1'b1, 1'b0);
    drive_beat(8'h00, 1'b1, 1'b1);
    drive_beat(8'hFF, 1'b1, 1'b0);
    drive_beat(8'hFF, 1'b1, 1'b0);
    drive_beat(8'hFF, 1'b1, 1'b1);
    // bare end marker flushing two pending bytes
    drive_beat(8'hAB, 1'b1, 1'b0);
    drive_beat(8'hCD, 1'b1, 1'b0);
    drive_beat(8'h5A, 1'b0, 1'b1);
    // bare end marker flushing one pending byte
    drive_beat(8'h80, 1'b1, 1'b0);
    drive_beat(8'h7F, 1'b0, 1'b1);
    // bare end marker right after a full group: CR LF alone
    drive_beat(8'h4D, 1'b1, 1'b0);
    drive_beat(8'h61, 1'b1, 1'b0);
    drive_beat(8'h6E, 1'b1, 1'b0);
    drive_beat(8'h00, 1'b0, 1'b1);

    // a few short random messages, some closed by a bare end marker
    while (in_beats_driven < 28) drive_message($urandom_range(0, 9), 1'b1);
    // 19 full groups: the wrap CR LF is the only one at the end
    drive_message(57, 1'b0);
    // 18 groups plus a padded partial group that lands exactly on column 76
    drive_message(55 + $urandom_range(0, 1), 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.close_out();

    $display("Covered %0d messages: %0d byte/end beats, %0d idle beats.",
             messages_done, beats_taken, ignored_taken);
    $display("Checked %0d output characters across %0d line wraps.",
             tracker.checked, tracker.wraps);
    if (tracker.errors == 0) begin
      $display("tb_base64_line_wrapped_encoder: done, clean");
    end else begin
      $display("tb_base64_line_wrapped_encoder: done, errors");
    end
    $finish;
  end

endmodule
